// ===== sv/image_conv_3x3_valid_assert.svh =====
// assertion macros for the 3x3 valid-region convolution block
`ifndef IMAGE_CONV_3X3_VALID_ASSERT_SVH
`define IMAGE_CONV_3X3_VALID_ASSERT_SVH

// condition holds at every clock edge out of reset
`define ICV_ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ICV_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/imgconv_pkg.sv =====
// shared types and constants of the 3x3 valid-region convolution block
package imgconv_pkg;

  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_MAX_HEIGHT = 64;

  localparam int PIXEL_W    = 8;
  localparam int WEIGHT_W   = 8;
  localparam int PROD_W     = 17;
  localparam int RSUM_W     = 19;
  localparam int VALUE_W    = 20;
  localparam int COORD_W    = 6;
  localparam int SIZE_CFG_W = 7;
  localparam int KERNEL_W   = 24;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int KSIZE      = 3;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [SIZE_CFG_W-1:0] WIDTH_RESET  = 7'd28;
  localparam logic [SIZE_CFG_W-1:0] HEIGHT_RESET = 7'd28;
  localparam logic [KERNEL_W-1:0]   KTOP_RESET   = 24'h0100FF;
  localparam logic [KERNEL_W-1:0]   KMID_RESET   = 24'h0200FE;
  localparam logic [KERNEL_W-1:0]   KBOT_RESET   = 24'h0100FF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH   = 3'd0,
    CFG_IMAGE_HEIGHT  = 3'd1,
    CFG_KERNEL_TOP    = 3'd2,
    CFG_KERNEL_MIDDLE = 3'd3,
    CFG_KERNEL_BOTTOM = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic               res;
    logic               last;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } meta_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [COORD_W-1:0]        col;
    logic [COORD_W-1:0]        row;
    logic                      last;
  } result_t;

endpackage

// ===== sv/image_conv_3x3_valid.sv =====
// top level of the 3x3 valid-region convolution block
// Takes one 8-bit pixel per clock in raster order and gives one signed 20-bit
// 3x3 convolution result for every pixel at row >= 2 and column >= 2 of its
// frame, tagged with its output column, output row and a last-of-frame flag.
// A new pixel is accepted every cycle unless in_stall is raised. A result
// goes through line ram read, window shift, nine multiplies, row sums and
// final sum and then waits in an 8-entry output queue. The input stalls only
// when that queue plus the results still in the pipeline would fill it, so a
// sink that takes one result per cycle sees no stall. Two line rams of
// MAX_WIDTH bytes hold the previous two rows; their contents are not cleared
// by reset. Assert frame_start with the first pixel of every frame.
`include "image_conv_3x3_valid_assert.svh"

module image_conv_3x3_valid
  import imgconv_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [PIXEL_W-1:0]        pixel_i,
  input  logic                      frame_start_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [VALUE_W-1:0] conv_value_o,
  output logic [COORD_W-1:0]        out_col_o,
  output logic [COORD_W-1:0]        out_row_o,
  output logic                      frame_last_o
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int WXW = (CW + 1 > SIZE_CFG_W) ? CW + 1 : SIZE_CFG_W;
  localparam int HXW = (RW + 1 > SIZE_CFG_W) ? RW + 1 : SIZE_CFG_W;
  localparam int CXW = (CW > COORD_W) ? CW : COORD_W;
  localparam int RXW = (RW > COORD_W) ? RW : COORD_W;

  // configuration
  logic [SIZE_CFG_W-1:0] width_q, height_q;
  logic [KERNEL_W-1:0]   kern_q [KSIZE];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= WIDTH_RESET;
      height_q  <= HEIGHT_RESET;
      kern_q[0] <= KTOP_RESET;
      kern_q[1] <= KMID_RESET;
      kern_q[2] <= KBOT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_IMAGE_WIDTH:   width_q   <= cfg_data_i[SIZE_CFG_W-1:0];
        CFG_IMAGE_HEIGHT:  height_q  <= cfg_data_i[SIZE_CFG_W-1:0];
        CFG_KERNEL_TOP:    kern_q[0] <= cfg_data_i[KERNEL_W-1:0];
        CFG_KERNEL_MIDDLE: kern_q[1] <= cfg_data_i[KERNEL_W-1:0];
        CFG_KERNEL_BOTTOM: kern_q[2] <= cfg_data_i[KERNEL_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped last column and last row
  logic [WXW-1:0] width_x;
  logic [HXW-1:0] height_x;
  logic [CW-1:0]  col_last;
  logic [RW-1:0]  row_last;

  assign width_x  = WXW'(width_q);
  assign height_x = HXW'(height_q);

  always_comb begin
    if (width_x < WXW'(3)) begin
      col_last = CW'(2);
    end else if (width_x > WXW'(MAX_WIDTH)) begin
      col_last = CW'(MAX_WIDTH - 1);
    end else begin
      col_last = CW'(width_x - WXW'(1));
    end
    if (height_x < HXW'(3)) begin
      row_last = RW'(2);
    end else if (height_x > HXW'(MAX_HEIGHT)) begin
      row_last = RW'(MAX_HEIGHT - 1);
    end else begin
      row_last = RW'(height_x - HXW'(1));
    end
  end

  // position counters
  logic          in_accept;
  logic [CW-1:0] col_q, col_d, col_cur;
  logic [RW-1:0] row_q, row_d, row_cur;
  logic          row_end, frame_end;
  logic [CXW-1:0] col_ext;
  logic [RXW-1:0] row_ext;
  meta_t         meta_d;

  assign in_accept = in_valid_i && !in_stall_o;
  assign col_cur   = frame_start_i ? '0 : col_q;
  assign row_cur   = frame_start_i ? '0 : row_q;
  assign row_end   = col_cur >= col_last;
  assign frame_end = row_end && (row_cur >= row_last);
  assign col_ext   = CXW'(col_cur) - CXW'(2);
  assign row_ext   = RXW'(row_cur) - RXW'(2);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_accept) begin
      if (frame_end) begin
        col_d = '0;
        row_d = '0;
      end else if (row_end) begin
        col_d = '0;
        row_d = row_cur + RW'(1);
      end else begin
        col_d = col_cur + CW'(1);
        row_d = row_cur;
      end
    end
    meta_d.res  = (row_cur >= RW'(2)) && (col_cur >= CW'(2));
    meta_d.last = frame_end;
    meta_d.col  = col_ext[COORD_W-1:0];
    meta_d.row  = row_ext[COORD_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // line rams: mid holds row r-1, top holds row r-2
  logic [PIXEL_W-1:0] mid_rd, top_rd, top_val;
  logic               s1_v_q, s1_fwd_q;
  logic [CW-1:0]      s1_idx_q;
  logic [PIXEL_W-1:0] s1_px_q, byp_q;
  meta_t              s1_q, s2_q, s3_q, s4_q;

  imgconv_ram #(
    .WIDTH(PIXEL_W),
    .DEPTH(MAX_WIDTH)
  ) u_mid_ram (
    .clk_i  (clk_i),
    .we_i   (in_accept),
    .waddr_i(col_cur),
    .wdata_i(pixel_i),
    .re_i   (in_accept),
    .raddr_i(col_cur),
    .rdata_o(mid_rd)
  );

  imgconv_ram #(
    .WIDTH(PIXEL_W),
    .DEPTH(MAX_WIDTH)
  ) u_top_ram (
    .clk_i  (clk_i),
    .we_i   (s1_v_q),
    .waddr_i(s1_idx_q),
    .wdata_i(mid_rd),
    .re_i   (in_accept),
    .raddr_i(col_cur),
    .rdata_o(top_rd)
  );

  // top ram write comes from the registered mid read, bypass it on a repeated column
  assign top_val = s1_fwd_q ? byp_q : top_rd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q   <= 1'b0;
      s1_fwd_q <= 1'b0;
      s1_q     <= '0;
      s2_q     <= '0;
      s3_q     <= '0;
      s4_q     <= '0;
    end else begin
      s1_v_q   <= in_accept;
      s1_fwd_q <= in_accept && s1_v_q && (s1_idx_q == col_cur);
      s1_q     <= in_accept ? meta_d : '0;
      s2_q     <= s1_v_q ? s1_q : '0;
      s3_q     <= s2_q;
      s4_q     <= s3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_idx_q <= col_cur;
    s1_px_q  <= pixel_i;
    byp_q    <= mid_rd;
  end

  // 3x3 window, column 0 oldest
  logic [PIXEL_W-1:0] win_q [KSIZE][KSIZE];

  always_ff @(posedge clk_i) begin
    if (s1_v_q) begin
      for (int i = 0; i < KSIZE; i++) begin
        win_q[i][0] <= win_q[i][1];
        win_q[i][1] <= win_q[i][2];
      end
      win_q[0][2] <= top_val;
      win_q[1][2] <= mid_rd;
      win_q[2][2] <= s1_px_q;
    end
  end

  // products, row sums, final sum
  logic signed [PROD_W-1:0]  prod_d [KSIZE][KSIZE];
  logic signed [PROD_W-1:0]  prod_q [KSIZE][KSIZE];
  logic signed [RSUM_W-1:0]  rsum_d [KSIZE];
  logic signed [RSUM_W-1:0]  rsum_q [KSIZE];
  logic signed [VALUE_W-1:0] total;

  always_comb begin
    for (int i = 0; i < KSIZE; i++) begin
      for (int k = 0; k < KSIZE; k++) begin
        prod_d[i][k] = PROD_W'($signed({1'b0, win_q[i][k]}))
                     * PROD_W'($signed(kern_q[i][WEIGHT_W*k +: WEIGHT_W]));
      end
      rsum_d[i] = RSUM_W'(prod_q[i][0]) + RSUM_W'(prod_q[i][1])
                + RSUM_W'(prod_q[i][2]);
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    rsum_q <= rsum_d;
  end

  assign total = VALUE_W'(rsum_q[0]) + VALUE_W'(rsum_q[1]) + VALUE_W'(rsum_q[2]);

  // output queue with credit on results still in the pipeline
  result_t              fifo_q [FIFO_DEPTH];
  result_t              push_entry;
  logic [FIFO_AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [FIFO_CW-1:0]   fifo_cnt_q;
  logic [2:0]           inflight;
  logic [FIFO_CW:0]     credit_used;
  logic                 push, pop;

  assign inflight    = 3'(s1_q.res) + 3'(s2_q.res) + 3'(s3_q.res) + 3'(s4_q.res);
  assign credit_used = (FIFO_CW + 1)'(fifo_cnt_q) + (FIFO_CW + 1)'(inflight);
  assign in_stall_o  = credit_used >= (FIFO_CW + 1)'(FIFO_DEPTH);

  assign push = s4_q.res;
  assign pop  = out_valid_o && !out_stall_i;

  assign push_entry.value = total;
  assign push_entry.col   = s4_q.col;
  assign push_entry.row   = s4_q.row;
  assign push_entry.last  = s4_q.last;

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= push_entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
      end
      if (push && !pop) begin
        fifo_cnt_q <= fifo_cnt_q + FIFO_CW'(1);
      end else if (pop && !push) begin
        fifo_cnt_q <= fifo_cnt_q - FIFO_CW'(1);
      end
    end
  end

  assign out_valid_o  = fifo_cnt_q != '0;
  assign conv_value_o = fifo_q[rd_ptr_q].value;
  assign out_col_o    = fifo_q[rd_ptr_q].col;
  assign out_row_o    = fifo_q[rd_ptr_q].row;
  assign frame_last_o = fifo_q[rd_ptr_q].last;

  // checks
  `ICV_ASSERT_ALWAYS(a_credit_bound, clk_i, rst_ni,
    credit_used <= (FIFO_CW + 1)'(FIFO_DEPTH), "output queue credit overrun")
  `ICV_ASSERT_NEXT(a_queue_fill, clk_i, rst_ni, push && !pop,
    fifo_cnt_q == $past(fifo_cnt_q) + FIFO_CW'(1), "queue count missed a push")
  `ICV_ASSERT_NEXT(a_result_enters, clk_i, rst_ni, in_accept && meta_d.res,
    s1_v_q && s1_q.res, "accepted result transaction lost in pipeline")
  `ICV_ASSERT_ALWAYS(a_bypass_valid, clk_i, rst_ni, !s1_fwd_q || s1_v_q,
    "line ram bypass without a transaction")

endmodule

// ===== sv/imgconv_ram.sv =====
// generic single-clock ram, one write port and one registered read port
module imgconv_ram
  import imgconv_pkg::*;
#(
  parameter int WIDTH = PIXEL_W,
  parameter int DEPTH = DEF_MAX_WIDTH,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== test/tb_image_conv_3x3_valid.sv =====
// self-checking testbench for the 3x3 valid-region convolution block
`timescale 1ns / 100ps

module tb_image_conv_3x3_valid;
  import imgconv_pkg::*;

  localparam int MAXW = DEF_MAX_WIDTH;
  localparam int MAXH = DEF_MAX_HEIGHT;
  localparam int SETTLE_CYCLES = 20;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic               start;
  } pixel_item_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]     cfg_data_i = '0;
  logic                      in_valid_i = 1'b0;
  logic                      in_stall_o;
  logic [PIXEL_W-1:0]        pixel_i = '0;
  logic                      frame_start_i = 1'b0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic signed [VALUE_W-1:0] conv_value_o;
  logic [COORD_W-1:0]        out_col_o;
  logic [COORD_W-1:0]        out_row_o;
  logic                      frame_last_o;

  image_conv_3x3_valid dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .pixel_i      (pixel_i),
    .frame_start_i(frame_start_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .conv_value_o (conv_value_o),
    .out_col_o    (out_col_o),
    .out_row_o    (out_row_o),
    .frame_last_o (frame_last_o)
  );

  // shadow of the register file
  logic [SIZE_CFG_W-1:0] width_reg;
  logic [SIZE_CFG_W-1:0] height_reg;
  logic [KERNEL_W-1:0]   kernel_reg [KSIZE];

  // predicted line rams, window and position
  logic [PIXEL_W-1:0] row_mem [2*MAXW];
  logic [PIXEL_W-1:0] win [9];
  logic [COORD_W-1:0] col_pos;
  logic [COORD_W-1:0] row_pos;
  result_t            conv_q [$];

  pixel_item_t pixel_q [$];
  bit          pixel_taken = 1'b0;
  bit          no_gaps = 1'b0;
  int          gap_left = 0;
  int          hold_left = 0;
  int          pixels_queued = 0;
  int          pixels_done = 0;
  int          results_done = 0;
  int          settings_used = 0;
  int          fail_count = 0;

  always #4 clk_i = ~clk_i;

  function automatic int clamp_size(input logic [SIZE_CFG_W-1:0] v, input int maxv);
    if (v < 3) return 3;
    if (v > maxv) return maxv;
    return int'(v);
  endfunction

  function automatic int idle_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 25);
  endfunction

  function automatic logic [KERNEL_W-1:0] random_kernel_row();
    case ($urandom_range(0, 11))
      0: return 24'h808080;
      1: return 24'h7F7F7F;
      2: return 24'h000000;
      default: return KERNEL_W'($urandom_range(0, 24'hFFFFFF));
    endcase
  endfunction

  function automatic void convolve_pixel(input logic [PIXEL_W-1:0] px, input logic start);
    int                        w;
    int                        h;
    int                        acc;
    int                        i;
    int                        k;
    logic [PIXEL_W-1:0]        top;
    logic [PIXEL_W-1:0]        mid;
    logic signed [WEIGHT_W-1:0] wgt;
    logic                      row_end;
    logic                      frame_end;
    result_t                   res;
    w = clamp_size(width_reg, MAXW);
    h = clamp_size(height_reg, MAXH);
    if (start) begin
      col_pos = '0;
      row_pos = '0;
    end
    top = row_mem[MAXW + col_pos];
    mid = row_mem[col_pos];
    row_mem[MAXW + col_pos] = mid;
    row_mem[col_pos] = px;
    for (i = 0; i < KSIZE; i++) begin
      win[3*i]   = win[3*i+1];
      win[3*i+1] = win[3*i+2];
    end
    win[2] = top;
    win[5] = mid;
    win[8] = px;
    row_end   = int'(col_pos) >= w - 1;
    frame_end = row_end && (int'(row_pos) >= h - 1);
    if (row_pos >= 2 && col_pos >= 2) begin
      acc = 0;
      for (i = 0; i < KSIZE; i++) begin
        for (k = 0; k < KSIZE; k++) begin
          wgt = kernel_reg[i][8*k +: 8];
          acc += int'(win[3*i+k]) * int'(wgt);
        end
      end
      res.value = acc[VALUE_W-1:0];
      res.col   = col_pos - COORD_W'(2);
      res.row   = row_pos - COORD_W'(2);
      res.last  = frame_end;
      conv_q.push_back(res);
    end
    if (frame_end) begin
      col_pos = '0;
      row_pos = '0;
    end else if (row_end) begin
      col_pos = '0;
      row_pos = row_pos + COORD_W'(1);
    end else begin
      col_pos = col_pos + COORD_W'(1);
    end
  endfunction

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    case (idx)
      CFG_IMAGE_WIDTH:   width_reg = data[SIZE_CFG_W-1:0];
      CFG_IMAGE_HEIGHT:  height_reg = data[SIZE_CFG_W-1:0];
      CFG_KERNEL_TOP:    kernel_reg[0] = data;
      CFG_KERNEL_MIDDLE: kernel_reg[1] = data;
      CFG_KERNEL_BOTTOM: kernel_reg[2] = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_config(input logic [SIZE_CFG_W-1:0] wcfg,
                             input logic [SIZE_CFG_W-1:0] hcfg,
                             input logic [KERNEL_W-1:0] ktop,
                             input logic [KERNEL_W-1:0] kmid,
                             input logic [KERNEL_W-1:0] kbot);
    write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(wcfg));
    write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(hcfg));
    write_reg(CFG_KERNEL_TOP, ktop);
    write_reg(CFG_KERNEL_MIDDLE, kmid);
    write_reg(CFG_KERNEL_BOTTOM, kbot);
    settings_used++;
  endtask

  task automatic queue_pixel(input logic [PIXEL_W-1:0] px, input logic start);
    pixel_item_t item;
    item.pixel = px;
    item.start = start;
    pixel_q.push_back(item);
    pixels_queued++;
  endtask

  task automatic queue_frame(input logic start, input int count);
    for (int i = 0; i < count; i++) queue_pixel(PIXEL_W'($urandom_range(0, 255)), start && i == 0);
  endtask

  // wait until every pixel is taken and every result checked, then let the pipe empty
  task automatic settle();
    while (pixels_done != pixels_queued || conv_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin : pixel_driver
    pixel_item_t item;
    if (rst_ni && (!in_valid_i || pixel_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pixel_q.size() > 0) begin
        item = pixel_q.pop_front();
        pixel_i       <= item.pixel;
        frame_start_i <= item.start;
        in_valid_i    <= 1'b1;
        gap_left = no_gaps ? 0 : idle_length();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin : result_stall
    if (hold_left > 0) begin
      hold_left--;
    end else if (out_stall_i) begin
      out_stall_i <= 1'b0;
      hold_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 6);
    end else begin
      out_stall_i <= 1'b1;
      hold_left = idle_length();
    end
  end

  always @(posedge clk_i) begin : result_monitor
    result_t want;
    // pixel transaction
    pixel_taken = rst_ni && in_valid_i && !in_stall_o;
    if (pixel_taken) begin
      convolve_pixel(pixel_i, frame_start_i);
      pixels_done++;
    end
    // result transaction
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (conv_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result: value %0d col %0d row %0d last %0b",
                   conv_value_o, out_col_o, out_row_o, frame_last_o);
      end else begin
        want = conv_q.pop_front();
        results_done++;
        if (conv_value_o !== want.value || out_col_o !== want.col ||
            out_row_o !== want.row || frame_last_o !== want.last) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: expected value %0d col %0d row %0d last %0b, got %0d %0d %0d %0b",
                     want.value, want.col, want.row, want.last,
                     conv_value_o, out_col_o, out_row_o, frame_last_o);
        end
      end
    end
  end

  initial begin : stimulus
    logic [SIZE_CFG_W-1:0] wcfg;
    logic [SIZE_CFG_W-1:0] hcfg;
    int                    w_eff;
    int                    h_eff;
    int                    frames;
    int                    frame_len;
    int                    random_pixels;
    bit                    need_start;
    width_reg     = WIDTH_RESET;
    height_reg    = HEIGHT_RESET;
    kernel_reg[0] = KTOP_RESET;
    kernel_reg[1] = KMID_RESET;
    kernel_reg[2] = KBOT_RESET;
    foreach (row_mem[i]) row_mem[i] = '0;
    foreach (win[i]) win[i] = '0;
    col_pos = '0;
    row_pos = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // most negative sum, undersized width and height
    load_config(7'd1, 7'd0, 24'h808080, 24'h808080, 24'h808080);
    for (int i = 0; i < 9; i++) queue_pixel(8'hFF, i == 0);
    settle();

    // most positive sum, oversized height, frame left open
    load_config(7'd2, 7'd127, 24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F);
    for (int i = 0; i < 9; i++) queue_pixel(8'hFF, i == 0);
    queue_pixel(8'h00, 1'b0);
    queue_pixel(8'hAA, 1'b0);
    queue_pixel(8'h55, 1'b0);
    settle();

    // height cut below the current row mid-frame, then restarts mid-frame
    load_config(7'd3, 7'd3, KTOP_RESET, KMID_RESET, KBOT_RESET);
    queue_pixel(8'h0F, 1'b0);
    queue_pixel(8'hF0, 1'b0);
    queue_pixel(8'hFF, 1'b0);
    queue_pixel(8'h01, 1'b1);
    queue_pixel(8'h80, 1'b0);
    queue_pixel(8'h7F, 1'b1);
    settle();

    // widest rows with no input gaps, then the tallest frame
    no_gaps = 1'b1;
    load_config(7'd127, 7'd3, random_kernel_row(), random_kernel_row(), random_kernel_row());
    queue_frame(1'b1, MAXW * 3);
    settle();
    no_gaps = 1'b0;
    load_config(7'd3, 7'd64, random_kernel_row(), random_kernel_row(), random_kernel_row());
    queue_frame(1'b1, 3 * MAXH);
    settle();
    random_pixels = MAXW * 3 + 3 * MAXH;

    // small frames, some cut short by a new frame start, some chained without one
    while (random_pixels < 400) begin
      wcfg = ($urandom_range(0, 9) == 0) ? SIZE_CFG_W'($urandom_range(0, 2))
                                         : SIZE_CFG_W'($urandom_range(3, 8));
      hcfg = ($urandom_range(0, 9) == 0) ? SIZE_CFG_W'($urandom_range(0, 2))
                                         : SIZE_CFG_W'($urandom_range(3, 8));
      load_config(wcfg, hcfg, random_kernel_row(), random_kernel_row(), random_kernel_row());
      w_eff = clamp_size(wcfg, MAXW);
      h_eff = clamp_size(hcfg, MAXH);
      no_gaps = ($urandom_range(0, 4) == 0);
      frames = $urandom_range(1, 3);
      need_start = 1'b1;
      for (int f = 0; f < frames; f++) begin
        frame_len = w_eff * h_eff;
        if ($urandom_range(0, 6) == 0) frame_len = $urandom_range(1, w_eff * h_eff - 1);
        queue_frame(need_start || $urandom_range(0, 4) != 0, frame_len);
        need_start = frame_len < w_eff * h_eff;
        random_pixels += frame_len;
      end
      settle();
    end
    no_gaps = 1'b0;

    fail_count += conv_q.size();
    $display("covered %0d pixels and %0d checked results over %0d register settings",
             pixels_done, results_done, settings_used);
    $display("sizes 3x3 up to 64 wide and 64 tall, extreme kernels, mid-frame restarts");
    if (fail_count == 0) begin
      $display("image_conv_3x3_valid regression: pass");
    end else begin
      $display("image_conv_3x3_valid regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #(6_000_000);
    $display("image_conv_3x3_valid regression: fail");
    $finish;
  end

endmodule
